>>> hdl/isg_pkg.sv
// shared types and constants for the greedy interval scheduler
// no dependencies
package isg_pkg;

    localparam int MAX_JOBS  = 64;
    localparam int TIME_BITS = 16;
    localparam int IDX_BITS  = 6;
    localparam int ADDR_BITS = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_JOBS + 1);

    typedef struct packed {
        logic [15:0] job_start;
        logic [15:0] job_end;
        logic        last_job;
    } t_job_in;

    typedef struct packed {
        logic [5:0]  job_index;
        logic [15:0] chosen_start;
        logic [15:0] chosen_end;
        logic        final_choice;
        logic        overflowed;
    } t_job_out;

    // one stored job: arrival index, start and end
    typedef struct packed {
        logic [IDX_BITS-1:0]  idx;
        logic [TIME_BITS-1:0] t_start;
        logic [TIME_BITS-1:0] t_end;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

endpackage

>>> hdl/isg_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module isg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

>>> hdl/interval_scheduling_greedy.sv
// top level of the greedy earliest-finish interval scheduler
// depends on isg_pkg and isg_ram
// an item is placed by sorted insertion: written straight in when the store is empty,
// dropped when it is full, else stored jobs that end later are shifted up one place each
// the item marked last then runs a scan over the N stored jobs (ST_SC_RD, ST_SCAN), then
// a flush; results come one a cycle at most and cannot be stalled
// the store memory has one read and one write port; that port pair sets the rate
// synchronous active-low reset clears count, drop flag and state; store is not cleared
module interval_scheduling_greedy (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  isg_pkg::t_job_in  i_job,
    output logic            o_strobe,
    output isg_pkg::t_job_out o_result
);
    import isg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_PUT,
        ST_SC_RD,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_drop;
    logic [ADDR_BITS-1:0]  r_ptr;
    t_slot                 r_new;
    logic                  r_last;
    t_slot                 r_pend;
    logic                  r_have;

    // memory port signals
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    t_slot                 wr_data;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [SLOT_BITS-1:0]  rd_raw;
    t_slot                 rd_slot;

    logic                  accept;
    logic                  full;
    logic [CNT_BITS-1:0]   count_m1;
    logic                  shift;
    logic                  taken;
    t_slot                 in_slot;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_count == CNT_BITS'(MAX_JOBS));
    assign count_m1 = r_count - CNT_BITS'(1);
    assign rd_slot  = t_slot'(rd_raw);

    // incoming job with its arrival index, times cut to TIME_BITS
    assign in_slot.idx     = IDX_BITS'(r_count);
    assign in_slot.t_start = TIME_BITS'(i_job.job_start);
    assign in_slot.t_end   = TIME_BITS'(i_job.job_end);

    // stored job ends after the new one: move it up a place
    assign shift = (rd_slot.t_end > r_new.t_end);
    // first job always taken, later ones when they start at or after the last end
    assign taken = !r_have || (rd_slot.t_start >= r_pend.t_end);

    isg_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (MAX_JOBS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    // memory access per state; the read for the next entry goes out while the
    // current one is compared, writes only land above the entry being read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr + ADDR_BITS'(1);
        wr_data = r_new;
        rd_addr = ADDR_BITS'(count_m1);
        case (r_state)
            ST_IDLE: begin
                // empty store: the job goes straight to the bottom entry
                wr_en   = accept && (r_count == '0);
                wr_addr = '0;
                wr_data = in_slot;
            end
            ST_INS: begin
                wr_en   = 1'b1;
                wr_data = shift ? rd_slot : r_new;
                rd_addr = r_ptr - ADDR_BITS'(1);
            end
            ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
            ST_SC_RD: begin
                rd_addr = '0;
            end
            ST_SCAN: begin
                rd_addr = r_ptr + ADDR_BITS'(1);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_have   <= 1'b0;
            r_ptr    <= '0;
            r_last   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_new  <= in_slot;
                        r_last <= i_job.last_job;
                        r_ptr  <= ADDR_BITS'(count_m1);
                        if (full) begin
                            // no room: drop, but a last item still runs the set
                            r_drop <= 1'b1;
                            if (i_job.last_job) begin
                                r_state <= ST_SC_RD;
                            end
                        end else if (r_count == '0) begin
                            r_count <= r_count + CNT_BITS'(1);
                            if (i_job.last_job) begin
                                r_state <= ST_SC_RD;
                            end
                        end else begin
                            r_state <= ST_INS;
                        end
                    end
                end
                ST_INS: begin
                    if (shift) begin
                        if (r_ptr == '0) begin
                            r_state <= ST_PUT;
                        end else begin
                            r_ptr <= r_ptr - ADDR_BITS'(1);
                        end
                    end else begin
                        r_count <= r_count + CNT_BITS'(1);
                        r_state <= r_last ? ST_SC_RD : ST_IDLE;
                    end
                end
                ST_PUT: begin
                    r_count <= r_count + CNT_BITS'(1);
                    r_state <= r_last ? ST_SC_RD : ST_IDLE;
                end
                ST_SC_RD: begin
                    r_ptr   <= '0;
                    r_have  <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    // a taken job is held back until the next one shows it is not final
                    if (taken) begin
                        r_pend <= rd_slot;
                        r_have <= 1'b1;
                        if (r_have) begin
                            o_strobe                <= 1'b1;
                            o_result.job_index      <= r_pend.idx;
                            o_result.chosen_start   <= 16'(r_pend.t_start);
                            o_result.chosen_end     <= 16'(r_pend.t_end);
                            o_result.final_choice   <= 1'b0;
                            o_result.overflowed     <= r_drop;
                        end
                    end
                    if (CNT_BITS'(r_ptr) == count_m1) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_ptr <= r_ptr + ADDR_BITS'(1);
                    end
                end
                ST_FLUSH: begin
                    o_strobe                <= 1'b1;
                    o_result.job_index      <= r_pend.idx;
                    o_result.chosen_start   <= 16'(r_pend.t_start);
                    o_result.chosen_end     <= 16'(r_pend.t_end);
                    o_result.final_choice   <= 1'b1;
                    o_result.overflowed     <= r_drop;
                    // set done: clear for the next one
                    r_count <= '0;
                    r_drop  <= 1'b0;
                    r_have  <= 1'b0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
